@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the cipher unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define TFBC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define TFBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/tfbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Table feedback byte cipher package
// Widths, register map codes and the substitution table.
// ----------------------------------------------------------------------------
package tfbc_pkg;

   localparam int DATA_W    = 8;
   localparam int CSR_W     = 64;
   localparam int ADDR_W    = 6;
   localparam int LEN_W     = 5;
   localparam int KEY_VEC_W = 160;

   // Constant multiplier and shift for the folded seed byte.
   localparam logic [7:0] FOLD_MULT  = 8'hab;
   localparam int         FOLD_SHIFT = 9;

   // Register index, taken from paddr above the 8-byte register stride.
   typedef enum logic [2:0] {
      REG_KEY_0_7     = 3'd0,
      REG_KEY_8_15    = 3'd1,
      REG_KEY_16_19   = 3'd2,
      REG_KEY_LENGTH  = 3'd3,
      REG_DIRECTION   = 3'd4
   } reg_index_type;

   typedef logic [DATA_W-1:0] byte_type;

   localparam byte_type SBOX [256] = '{
      8'h7c, 8'h9c, 8'he8, 8'h4a, 8'h13, 8'hde, 8'hdc, 8'hb2, 8'h2f, 8'h21, 8'h23, 8'he4,
      8'h30, 8'h7b, 8'h3d, 8'h8c, 8'hbc, 8'h0b, 8'h27, 8'h0c, 8'h3c, 8'hf7, 8'h9a, 8'he7,
      8'h08, 8'h71, 8'h96, 8'h00, 8'h97, 8'h85, 8'hef, 8'hc1, 8'h1f, 8'hc4, 8'hdb, 8'ha1,
      8'hc2, 8'heb, 8'hd9, 8'h01, 8'hfa, 8'hba, 8'h3b, 8'h05, 8'hb8, 8'h15, 8'h87, 8'h83,
      8'h28, 8'h72, 8'hd1, 8'h8b, 8'h5a, 8'hd6, 8'hda, 8'h93, 8'h58, 8'hfe, 8'haa, 8'hcc,
      8'h6e, 8'h1b, 8'hf0, 8'ha3, 8'h88, 8'hab, 8'h43, 8'hc0, 8'h0d, 8'hb5, 8'h45, 8'h38,
      8'h4f, 8'h50, 8'h22, 8'h66, 8'h20, 8'h7f, 8'h07, 8'h5b, 8'h14, 8'h98, 8'h1d, 8'h9b,
      8'ha7, 8'h2a, 8'hb9, 8'ha8, 8'hcb, 8'hf1, 8'hfc, 8'h49, 8'h47, 8'h06, 8'h3e, 8'hb1,
      8'h0e, 8'h04, 8'h3a, 8'h94, 8'h5e, 8'hee, 8'h54, 8'h11, 8'h34, 8'hdd, 8'h4d, 8'hf9,
      8'hec, 8'hc7, 8'hc9, 8'he3, 8'h78, 8'h1a, 8'h6f, 8'h70, 8'h6b, 8'ha4, 8'hbd, 8'ha9,
      8'h5d, 8'hd5, 8'hf8, 8'he5, 8'hbb, 8'h26, 8'haf, 8'h42, 8'h37, 8'hd8, 8'he1, 8'h02,
      8'h0a, 8'hae, 8'h5f, 8'h1c, 8'hc5, 8'h73, 8'h09, 8'h4e, 8'h69, 8'h24, 8'h90, 8'h6d,
      8'h12, 8'hb3, 8'h19, 8'had, 8'h74, 8'h8a, 8'h29, 8'h40, 8'hf5, 8'h2d, 8'hbe, 8'ha5,
      8'h59, 8'he0, 8'hf4, 8'h79, 8'hd2, 8'h4b, 8'hce, 8'h89, 8'h82, 8'h48, 8'h84, 8'h25,
      8'hc6, 8'h91, 8'h2b, 8'ha2, 8'hfb, 8'h8f, 8'he9, 8'ha6, 8'hb0, 8'h9e, 8'h3f, 8'h65,
      8'hf6, 8'h03, 8'h31, 8'h2e, 8'hac, 8'h0f, 8'h95, 8'h2c, 8'h5c, 8'hed, 8'h39, 8'hb7,
      8'h33, 8'h6c, 8'h56, 8'h7e, 8'hb4, 8'ha0, 8'hfd, 8'h7a, 8'h81, 8'h53, 8'h51, 8'h86,
      8'h8d, 8'h9f, 8'h77, 8'hff, 8'h6a, 8'h80, 8'hdf, 8'he2, 8'hbf, 8'h10, 8'hd7, 8'h75,
      8'h64, 8'h57, 8'h76, 8'hf3, 8'h55, 8'hcd, 8'hd0, 8'hc8, 8'h18, 8'he6, 8'h36, 8'h41,
      8'h62, 8'hcf, 8'h99, 8'hf2, 8'h32, 8'h4c, 8'h67, 8'h60, 8'h61, 8'h92, 8'hca, 8'hd3,
      8'hea, 8'h63, 8'h7d, 8'h16, 8'hb6, 8'h8e, 8'hd4, 8'h68, 8'h35, 8'hc3, 8'h52, 8'h9d,
      8'h46, 8'h44, 8'h1e, 8'h17
   };

endpackage

@@ design/tfbc_ifs.sv @@
// ----------------------------------------------------------------------------
// Cipher unit channels
// Valid/ready interfaces for the input byte stream and the result stream.
// ----------------------------------------------------------------------------
interface tfbc_req_if;
   logic                        valid;
   logic                        ready;
   logic [tfbc_pkg::DATA_W-1:0] data_in;
   logic                        last_in;

   modport source (output valid, output data_in, output last_in, input ready);
   modport sink   (input valid, input data_in, input last_in, output ready);
endinterface

interface tfbc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tfbc_pkg::DATA_W-1:0] data_out;
   logic                        last_out;

   modport source (output valid, output data_out, output last_out, input ready);
   modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

@@ design/table_feedback_byte_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// Table feedback byte cipher unit
// Encrypts or decrypts a packet byte by byte with a table lookup keyed by
// the previous ciphertext byte and four seed bytes derived from the key.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                         Payload
//   req_if    in         valid & ready at clock edge       data_in, last_in
//   rsp_if    out        valid & ready at clock edge       data_out, last_out
//   csr_*     in/out     APB, written at psel&penable&pwrite  64-bit registers
//
// One item per cycle outside seed passes and register writes: the feedback loop
// (seed add, table lookup, XOR) closes through fb_ff and the result register
// is refilled while it drains. The result of an item is valid in the cycle
// after the item is accepted. Any register write holds req_if.ready low in its
// access cycle; a write to one of the five defined registers starts a seed
// derivation pass, one key byte per cycle; req_if.ready stays low in the pass.
// Reset is synchronous: zero key, pass-through, seeds zero, packet start set.
// A stalled result holds its register; a new item is then taken only if the
// result is drained in the same cycle.
//
`include "assert_macros.svh"

module table_feedback_byte_cipher_unit #(
   parameter int MAX_KEY_BYTES = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   tfbc_req_if.sink                      req_if,
   tfbc_rsp_if.source                    rsp_if,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tfbc_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [tfbc_pkg::CSR_W-1:0]    csr_pwdata,
   output logic [tfbc_pkg::CSR_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int CNT_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_KEY_BYTES - 1);
   localparam logic [tfbc_pkg::LEN_W-1:0] MAX_LEN = tfbc_pkg::LEN_W'(MAX_KEY_BYTES);

   // Configuration registers.
   logic [63:0]                   key_0_7_ff;
   logic [63:0]                   key_8_15_ff;
   logic [31:0]                   key_16_19_ff;
   logic [tfbc_pkg::LEN_W-1:0]    key_length_ff;
   logic                          direction_ff;

   // Seed derivation pass.
   logic                          busy_ff;
   logic [CNT_W-1:0]              cnt_ff;
   tfbc_pkg::byte_type            sum_ff, fold_ff, xor_ff;
   tfbc_pkg::byte_type            sum_in, fold_in, xor_in;
   tfbc_pkg::byte_type            seed_ff [4];

   // Stream state and result register.
   tfbc_pkg::byte_type            fb_ff;
   logic                          at_start_ff;
   logic                          rsp_valid_ff;
   tfbc_pkg::byte_type            rsp_data_ff;
   logic                          rsp_last_ff;

   logic                          csr_wr;
   logic                          csr_known;
   tfbc_pkg::reg_index_type       reg_idx;
   logic [tfbc_pkg::LEN_W-1:0]    used_len;
   logic [tfbc_pkg::KEY_VEC_W-1:0] key_vec;
   tfbc_pkg::byte_type            key_arr [MAX_KEY_BYTES];
   tfbc_pkg::byte_type            key_cur;
   logic [15:0]                   fold_prod;
   logic                          take_byte;
   logic                          req_accept;
   tfbc_pkg::byte_type            tbl_idx;
   tfbc_pkg::byte_type            result;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = tfbc_pkg::reg_index_type'(csr_paddr[tfbc_pkg::ADDR_W-1:3]);

   // Register read mux.
   always_comb begin
      csr_known = 1'b1;
      case (reg_idx)
         tfbc_pkg::REG_KEY_0_7:    csr_prdata = key_0_7_ff;
         tfbc_pkg::REG_KEY_8_15:   csr_prdata = key_8_15_ff;
         tfbc_pkg::REG_KEY_16_19:  csr_prdata = {32'd0, key_16_19_ff};
         tfbc_pkg::REG_KEY_LENGTH: csr_prdata = {59'd0, key_length_ff};
         tfbc_pkg::REG_DIRECTION:  csr_prdata = {63'd0, direction_ff};
         default: begin
            csr_prdata = '0;
            csr_known  = 1'b0;
         end
      endcase
   end

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_0_7_ff    <= '0;
         key_8_15_ff   <= '0;
         key_16_19_ff  <= '0;
         key_length_ff <= '0;
         direction_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (reg_idx)
            tfbc_pkg::REG_KEY_0_7:    key_0_7_ff    <= csr_pwdata;
            tfbc_pkg::REG_KEY_8_15:   key_8_15_ff   <= csr_pwdata;
            tfbc_pkg::REG_KEY_16_19:  key_16_19_ff  <= csr_pwdata[31:0];
            tfbc_pkg::REG_KEY_LENGTH: key_length_ff <= csr_pwdata[tfbc_pkg::LEN_W-1:0];
            tfbc_pkg::REG_DIRECTION:  direction_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Key length saturates at the configured maximum.
   assign used_len = (key_length_ff > MAX_LEN) ? MAX_LEN : key_length_ff;

   // Key bytes as an array, byte 0 lowest.
   assign key_vec = {key_16_19_ff, key_8_15_ff, key_0_7_ff};
   for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_key
      assign key_arr[i] = key_vec[8*i +: 8];
   end

   // One key byte of the seed sums per cycle during a seed pass.
   always_comb begin
      key_cur   = key_arr[cnt_ff];
      fold_prod = 16'(key_cur) * 16'(tfbc_pkg::FOLD_MULT);
      take_byte = tfbc_pkg::LEN_W'(cnt_ff) < used_len;
      sum_in    = sum_ff;
      fold_in   = fold_ff;
      xor_in    = xor_ff;
      if (take_byte) begin
         sum_in  = sum_ff + key_cur;
         fold_in = fold_ff + 8'(fold_prod >> tfbc_pkg::FOLD_SHIFT);
         xor_in  = xor_ff ^ key_cur;
      end
   end

   // Seed pass sequencer, restarted by every known register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         sum_ff  <= '0;
         fold_ff <= '0;
         xor_ff  <= '0;
         for (int s = 0; s < 4; s++) begin
            seed_ff[s] <= '0;
         end
      end else if (csr_wr && csr_known) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         sum_ff  <= '0;
         fold_ff <= '0;
         xor_ff  <= '0;
      end else if (busy_ff) begin
         sum_ff  <= sum_in;
         fold_ff <= fold_in;
         xor_ff  <= xor_in;
         cnt_ff  <= cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_CNT) begin
            busy_ff    <= 1'b0;
            seed_ff[0] <= sum_in;
            seed_ff[1] <= 8'd0 - sum_in;
            seed_ff[2] <= fold_in;
            seed_ff[3] <= xor_in;
         end
      end
   end

   // Input is taken outside seed passes and register writes, when the result register drains or is empty.
   assign req_if.ready = !busy_ff && !csr_wr && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;

   // Table index from the seeds and the previous ciphertext byte.
   always_comb begin
      if (at_start_ff) begin
         tbl_idx = seed_ff[0];
      end else begin
         tbl_idx = seed_ff[fb_ff[1:0]] + fb_ff;
      end
      if (used_len == '0) begin
         result = req_if.data_in;
      end else begin
         result = tfbc_pkg::SBOX[tbl_idx] ^ req_if.data_in;
      end
   end

   // Stream state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff        <= '0;
         at_start_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            at_start_ff  <= req_if.last_in;
            rsp_valid_ff <= 1'b1;
            if (used_len != '0) begin
               fb_ff <= direction_ff ? req_if.data_in : result;
            end
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
         rsp_last_ff <= req_if.last_in;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.data_out = rsp_data_ff;
   assign rsp_if.last_out = rsp_last_ff;

   // Checks on the pass sequencer and the data path.
   `TFBC_ASSERT(a_no_item_while_seeding, clock, reset, req_accept |-> !busy_ff, "item taken during seed pass")
   `TFBC_ASSERT(a_write_starts_pass, clock, reset, (csr_wr && csr_known) |=> busy_ff, "register write did not start seed pass")
   `TFBC_ASSERT(a_item_gives_result, clock, reset, req_accept |=> rsp_valid_ff, "accepted item left no result")
   `TFBC_ASSERT(a_pass_through, clock, reset, (req_accept && (used_len == '0)) |=> (rsp_data_ff == $past(req_if.data_in)), "pass-through byte altered")

endmodule

@@ verif/tfbc_cipher_monitor.sv @@
// ----------------------------------------------------------------------------
// Cipher unit stream monitor
// Watches the register port and both byte channels. It keeps its own copy of
// the key registers and of the packet feedback state, works out the expected
// output byte for every accepted input item, and compares each accepted
// result item field by field with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfbc_cipher_monitor #(
   parameter int MAX_KEY_BYTES = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [tfbc_pkg::DATA_W-1:0]   req_data,
   input  logic                          req_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [tfbc_pkg::DATA_W-1:0]   rsp_data,
   input  logic                          rsp_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic                          csr_pready,
   input  logic [tfbc_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [tfbc_pkg::CSR_W-1:0]    csr_pwdata,
   output int                            error_count,
   output int                            in_flight
);

   typedef struct packed {
      tfbc_pkg::byte_type data;
      logic               last;
   } cipher_byte_type;

   // Shadow copy of the key registers.
   logic [63:0] key_lo;
   logic [63:0] key_mid;
   logic [31:0] key_hi;
   logic [4:0]  key_len;
   logic        decrypt;

   // Packet feedback state.
   tfbc_pkg::byte_type feedback;
   logic               packet_start;

   cipher_byte_type expected_bytes[$];

   // Four seed bytes from the used key bytes: sum, negated sum, folded sum
   // and XOR, packed with seed 0 in the lowest byte.
   function automatic logic [31:0] seed_bytes(input logic [159:0] key_vec,
                                              input logic [4:0] len);
      int unsigned count;
      int unsigned sum;
      int unsigned folded;
      int unsigned xr;
      int unsigned kb;
      count  = (len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : len;
      sum    = 0;
      folded = 0;
      xr     = 0;
      for (int i = 0; i < count; i++) begin
         kb     = key_vec[8*i +: 8];
         sum    = sum + kb;
         xr     = xr ^ kb;
         folded = folded + ((kb * 171) >> 9);
      end
      return {xr[7:0], folded[7:0], 8'(0 - sum), sum[7:0]};
   endfunction

   // Only the first ten mismatches are described in full.
   task automatic note_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      if (error_count < 10) begin
         $display("[%0t] %s: expected %0h, got %0h", $realtime, what, want, got);
      end
      error_count = error_count + 1;
   endtask

   always @(posedge clock) begin : predict_and_compare
      logic [31:0]        seeds;
      tfbc_pkg::byte_type lookup_ix;
      tfbc_pkg::byte_type result_byte;
      cipher_byte_type    oldest;
      cipher_byte_type    queued;
      if (reset) begin
         key_lo       = '0;
         key_mid      = '0;
         key_hi       = '0;
         key_len      = '0;
         decrypt      = 1'b0;
         feedback     = '0;
         packet_start = 1'b1;
         expected_bytes.delete();
      end else begin
         // Register writes land at the access phase.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (tfbc_pkg::reg_index_type'(csr_paddr[tfbc_pkg::ADDR_W-1:3]))
               tfbc_pkg::REG_KEY_0_7:    key_lo  = csr_pwdata;
               tfbc_pkg::REG_KEY_8_15:   key_mid = csr_pwdata;
               tfbc_pkg::REG_KEY_16_19:  key_hi  = csr_pwdata[31:0];
               tfbc_pkg::REG_KEY_LENGTH: key_len = csr_pwdata[tfbc_pkg::LEN_W-1:0];
               tfbc_pkg::REG_DIRECTION:  decrypt = csr_pwdata[0];
               default: ;
            endcase
         end

         // Each accepted input item yields exactly one output byte.
         if (req_valid && req_ready) begin
            if (key_len == 0) begin
               result_byte = req_data;
            end else begin
               seeds = seed_bytes({key_hi, key_mid, key_lo}, key_len);
               if (packet_start) begin
                  lookup_ix = seeds[7:0];
               end else begin
                  lookup_ix = seeds[8*feedback[1:0] +: 8] + feedback;
               end
               result_byte = tfbc_pkg::SBOX[lookup_ix] ^ req_data;
               // The ciphertext byte feeds back in either direction.
               feedback    = decrypt ? req_data : result_byte;
            end
            packet_start   = req_last;
            queued.data    = result_byte;
            queued.last    = req_last;
            expected_bytes = {expected_bytes, queued};
         end

         // Compare the accepted result item with the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               note_mismatch("unexpected result item, data", 0, rsp_data);
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_data !== oldest.data) begin
                  note_mismatch("data_out", oldest.data, rsp_data);
               end
               if (rsp_last !== oldest.last) begin
                  note_mismatch("last_out", oldest.last, rsp_last);
               end
            end
         end
      end
      in_flight <= expected_bytes.size();
   end

   initial begin
      error_count = 0;
      in_flight   = 0;
   end

endmodule

@@ verif/table_feedback_byte_cipher_unit_test.sv @@
// ----------------------------------------------------------------------------
// Cipher unit testbench
// Drives packets of bytes through the cipher unit under a series of key,
// key length and direction settings, with random gaps on both channels and
// one long output stall. A monitor predicts every output byte and the top
// reports the verdict once all results have drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_feedback_byte_cipher_unit_test;

   localparam int MAX_KEY_BYTES = 20;
   localparam int ITEM_TARGET   = 1900;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;

   logic clock;
   logic reset;

   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [tfbc_pkg::ADDR_W-1:0]   csr_paddr;
   logic [tfbc_pkg::CSR_W-1:0]    csr_pwdata;
   logic [tfbc_pkg::CSR_W-1:0]    csr_prdata;
   logic                          csr_pready;

   tfbc_req_if req_ch ();
   tfbc_rsp_if rsp_ch ();

   int error_count;
   int in_flight;
   int items_sent;
   int idle_cycles;
   bit steady;
   bit hold_off_request;

   table_feedback_byte_cipher_unit #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tfbc_cipher_monitor #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES)
   ) monitor_u (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_data    (req_ch.data_in),
      .req_last    (req_ch.last_in),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_data    (rsp_ch.data_out),
      .rsp_last    (rsp_ch.last_out),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .error_count (error_count),
      .in_flight   (in_flight)
   );

   // Clock with a 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: ends the run when nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Output side: random back-pressure, one long hold-off on request.
   initial begin : receiver
      bit held;
      held         = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !held) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
         end
      end
   end

   // One APB write: setup cycle, then access cycle until pready.
   task automatic write_register(input tfbc_pkg::reg_index_type idx,
                                 input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one input item, with an occasional gap first, and wait until it
   // is taken. Entered and left at a falling edge.
   task automatic send_byte(input tfbc_pkg::byte_type data, input logic last);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.data_in <= data;
      req_ch.last_in <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent = items_sent + 1;
      @(negedge clock);
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
   endtask

   // Key length picks favor the edges: off, one byte, full and saturated.
   function automatic logic [63:0] pick_key_length();
      case ($urandom_range(0, 9))
         0:       return 64'd0;
         1:       return 64'd1;
         2:       return 64'd20;
         3:       return 64'($urandom_range(21, 31));
         default: return 64'($urandom_range(1, 20));
      endcase
   endfunction

   function automatic logic [63:0] pick_key_word();
      case ($urandom_range(0, 7))
         0:       return 64'd0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic tfbc_pkg::byte_type pick_data();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return tfbc_pkg::byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin : stimulus
      int       phase;
      int       burst;
      int       bytes_left;
      bit       noisy;
      logic     last;

      reset            = 1'b1;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_ch.valid     = 1'b0;
      req_ch.data_in   = '0;
      req_ch.last_in   = 1'b0;
      items_sent       = 0;
      steady           = 1'b0;
      hold_off_request = 1'b0;
      bytes_left       = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Pass-through straight after reset.
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      drain();

      // Full-length key of all ones, encrypting.
      write_register(tfbc_pkg::REG_KEY_0_7, '1);
      write_register(tfbc_pkg::REG_KEY_8_15, '1);
      write_register(tfbc_pkg::REG_KEY_16_19, 64'hffff_ffff);
      write_register(tfbc_pkg::REG_KEY_LENGTH, 64'd20);
      write_register(tfbc_pkg::REG_DIRECTION, 64'd0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'ha5, 1'b0);
      send_byte(8'h5a, 1'b1);
      drain();

      // Key length above the limit saturates; decrypting.
      write_register(tfbc_pkg::REG_KEY_LENGTH, 64'd31);
      write_register(tfbc_pkg::REG_DIRECTION, 64'd1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b1);
      drain();

      // Key, direction and key length changes in the middle of one packet.
      send_byte(8'h3c, 1'b0);
      drain();
      write_register(tfbc_pkg::REG_KEY_0_7, 64'h0123_4567_89ab_cdef);
      send_byte(8'hc3, 1'b0);
      drain();
      write_register(tfbc_pkg::REG_DIRECTION, 64'd0);
      send_byte(8'h77, 1'b0);
      drain();
      write_register(tfbc_pkg::REG_KEY_LENGTH, 64'd0);
      send_byte(8'h11, 1'b0);
      drain();
      write_register(tfbc_pkg::REG_KEY_LENGTH, 64'd1);
      send_byte(8'h22, 1'b1);
      drain();

      // Single-byte packets back to back.
      write_register(tfbc_pkg::REG_KEY_0_7, 64'h0);
      send_byte(8'h80, 1'b1);
      send_byte(8'h01, 1'b1);
      drain();

      // Random phases: new settings between bursts of packets. A burst may
      // end inside a packet, so the next settings apply mid-packet.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain();
         if ($urandom_range(0, 1)) write_register(tfbc_pkg::REG_KEY_0_7, pick_key_word());
         if ($urandom_range(0, 1)) write_register(tfbc_pkg::REG_KEY_8_15, pick_key_word());
         if ($urandom_range(0, 1)) begin
            write_register(tfbc_pkg::REG_KEY_16_19, {32'd0, $urandom()});
         end
         if ($urandom_range(0, 2)) begin
            write_register(tfbc_pkg::REG_KEY_LENGTH, pick_key_length());
         end
         if ($urandom_range(0, 1)) begin
            write_register(tfbc_pkg::REG_DIRECTION, 64'($urandom_range(0, 1)));
         end

         steady = (phase == 6) || (phase == 7);
         if (phase == 3) hold_off_request = 1'b1;
         burst = $urandom_range(40, 120);
         noisy = ($urandom_range(0, 9) == 0);
         repeat (burst) begin
            if (noisy) begin
               last = $urandom_range(0, 1);
            end else begin
               if (bytes_left == 0) bytes_left = $urandom_range(1, 24);
               last       = (bytes_left == 1);
               bytes_left = bytes_left - 1;
            end
            send_byte(pick_data(), last);
         end
         phase = phase + 1;
      end
      steady = 1'b0;

      // Let everything drain, then allow a few more cycles for stray output.
      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && in_flight == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
